FILE: sv/ffpra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpra_pkg
// Shared types and constants of the first-fit page run allocator.
// ----------------------------------------------------------------------------
package ffpra_pkg;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned SHIFT_W     = 5;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned WORD_BITS   = 8;
   localparam int unsigned WORD_SHIFT  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_SHIFT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_SHIFT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 2'd2;

   localparam logic [SHIFT_W-1:0] COUNT_SHIFT_RST  = 5'd12;
   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST   = 5'd9;
   localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'h0200_0000;

   localparam logic MODE_ALLOC     = 1'b0;
   localparam logic MODE_FREE      = 1'b1;
   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_NO_ROOM = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] byte_count;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_address;
      logic              status;
   } rsp_type;

   typedef enum logic [1:0] {
      RSP_ALLOC = 2'd0,
      RSP_FAIL  = 2'd1,
      RSP_FREE  = 2'd2
   } rsp_kind_type;

   typedef struct packed {
      logic         take;
      logic         scan_run;
      logic         mark_init;
      logic         free_init;
      logic         walk_run;
      logic         clear_step;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic too_big;
      logic in_range;
      logic run_zero;
      logic scan_hit;
      logic scan_end;
      logic walk_done;
      logic clear_done;
   } sts_type;

endpackage

FILE: sv/ffpra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpra_dp
// Datapath: config registers, page-used bitmap and run-length memories,
// first-fit scan one bitmap word per cycle, mark/clear walk, result register.
// ----------------------------------------------------------------------------
module ffpra_dp #(
   parameter int unsigned NUM_PAGES = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [ffpra_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ffpra_pkg::ADDR_W-1:0]           csr_wr_data,
   input  ffpra_pkg::req_type                     req_data,
   input  ffpra_pkg::cmd_type                     cmd,
   output ffpra_pkg::sts_type                     sts,
   output ffpra_pkg::rsp_type                     rsp_data
);

   localparam int unsigned AW    = ffpra_pkg::ADDR_W;
   localparam int unsigned SW    = ffpra_pkg::SHIFT_W;
   localparam int unsigned WB    = ffpra_pkg::WORD_BITS;
   localparam int unsigned WS    = ffpra_pkg::WORD_SHIFT;
   localparam int unsigned PW    = $clog2(NUM_PAGES);
   localparam int unsigned PCW   = $clog2(NUM_PAGES + 1);
   localparam int unsigned WORDS = (NUM_PAGES + WB - 1) / WB;
   localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned WCW   = $clog2(WORDS + 1);
   localparam int unsigned PIW   = WAW + WS;
   localparam logic [AW-1:0]  NUM_PAGES_W = AW'(NUM_PAGES);
   localparam logic [AW-1:0]  WORDS_W     = AW'(WORDS);
   localparam logic [WAW-1:0] LAST_WORD   = WAW'(WORDS - 1);
   localparam logic [PW-1:0]  LAST_PAGE   = PW'(NUM_PAGES - 1);

   logic [SW-1:0]  cs_ff, ps_ff;
   logic [AW-1:0]  base_ff;

   logic [PCW-1:0] pages_ff;
   logic           too_big_ff;
   logic [PW-1:0]  page_ff;
   logic           in_range_ff;

   logic [WCW-1:0] rd_word_ff;
   logic           rd_valid_ff;
   logic [WAW-1:0] dword_ff;
   logic [PCW-1:0] len_ff;
   logic [PW-1:0]  first_ff;
   logic [PW-1:0]  start_ff;
   logic [PW-1:0]  lo_ff;
   logic [PCW-1:0] hi_ff;
   logic [WAW-1:0] last_word_ff;
   logic           set_ff;
   logic [PW-1:0]  clr_ff;
   logic [WB-1:0]  bm_rd_ff;
   logic [PCW-1:0] rl_rd_ff;
   ffpra_pkg::rsp_type rsp_ff;

   logic [WB-1:0]  bm_mem [WORDS];
   logic [PCW-1:0] rl_mem [NUM_PAGES];

   logic [AW-1:0]  shifted, offset, page_wide, alloc_addr;
   logic           too_big_in, in_range_in;
   logic [PCW-1:0] pages_in;

   logic [PCW-1:0] len_v;
   logic [PW-1:0]  first_v, hit_start_v;
   logic           hit_v;
   logic [PCW-1:0] alloc_hi, free_hi;
   logic [WB-1:0]  mask, bm_wdata;
   logic           scan_issue, walk_issue, issue;
   logic           bm_we;
   logic [WAW-1:0] bm_waddr;
   logic           rl_we;
   logic [PW-1:0]  rl_waddr;
   logic [PCW-1:0] rl_wdata;

   // request decode
   always_comb begin
      shifted     = req_data.byte_count >> cs_ff;
      too_big_in  = shifted >= NUM_PAGES_W;
      pages_in    = PCW'(shifted) + PCW'(1);
      offset      = req_data.address - base_ff;
      page_wide   = offset >> ps_ff;
      in_range_in = (req_data.address >= base_ff) && (page_wide < NUM_PAGES_W);
   end

   // first-fit evaluation of one bitmap word
   always_comb begin
      logic [PIW-1:0] pidx;
      logic           used;
      len_v       = len_ff;
      first_v     = first_ff;
      hit_v       = 1'b0;
      hit_start_v = first_ff;
      for (int i = 0; i < WB; i++) begin
         pidx = {dword_ff, WS'(i)};
         used = bm_rd_ff[i] || (AW'(pidx) >= NUM_PAGES_W);
         if (used) begin
            len_v = '0;
         end else begin
            if (len_v == '0) begin
               first_v = PW'(pidx);
            end
            len_v = len_v + PCW'(1);
         end
         if (!hit_v && (len_v == pages_ff)) begin
            hit_v       = 1'b1;
            hit_start_v = first_v;
         end
      end
   end

   // walk mask for the word in flight
   always_comb begin
      logic [PIW-1:0] pidx;
      for (int i = 0; i < WB; i++) begin
         pidx    = {dword_ff, WS'(i)};
         mask[i] = (AW'(pidx) >= AW'(lo_ff)) && (AW'(pidx) < AW'(hi_ff));
      end
      bm_wdata = set_ff ? (bm_rd_ff | mask) : (bm_rd_ff & ~mask);
   end

   assign alloc_hi   = PCW'(hit_start_v) + pages_ff;
   assign free_hi    = PCW'(page_ff) + rl_rd_ff;
   assign alloc_addr = base_ff + (AW'(start_ff) << ps_ff);

   assign scan_issue = cmd.scan_run && (AW'(rd_word_ff) < WORDS_W);
   assign walk_issue = cmd.walk_run && (AW'(rd_word_ff) <= AW'(last_word_ff));
   assign issue      = scan_issue || walk_issue;

   always_comb begin
      bm_we    = 1'b0;
      bm_waddr = dword_ff;
      if (cmd.clear_step && (AW'(clr_ff) < WORDS_W)) begin
         bm_we    = 1'b1;
         bm_waddr = WAW'(clr_ff);
      end else if (cmd.walk_run && rd_valid_ff) begin
         bm_we    = 1'b1;
      end
   end

   always_comb begin
      rl_we    = cmd.clear_step || cmd.mark_init || cmd.free_init;
      rl_waddr = page_ff;
      rl_wdata = '0;
      if (cmd.clear_step) begin
         rl_waddr = clr_ff;
      end else if (cmd.mark_init) begin
         rl_waddr = hit_start_v;
         rl_wdata = pages_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bm_mem[bm_waddr] <= bm_wdata;
      end
      bm_rd_ff <= bm_mem[rd_word_ff[WAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rl_we) begin
         rl_mem[rl_waddr] <= rl_wdata;
      end
      rl_rd_ff <= rl_mem[page_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff       <= ffpra_pkg::COUNT_SHIFT_RST;
         ps_ff       <= ffpra_pkg::PAGE_SHIFT_RST;
         base_ff     <= ffpra_pkg::BASE_ADDRESS_RST;
         rd_valid_ff <= 1'b0;
         clr_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               ffpra_pkg::CSR_COUNT_SHIFT:  cs_ff   <= csr_wr_data[SW-1:0];
               ffpra_pkg::CSR_PAGE_SHIFT:   ps_ff   <= csr_wr_data[SW-1:0];
               ffpra_pkg::CSR_BASE_ADDRESS: base_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.take || cmd.mark_init || cmd.free_init) begin
            rd_valid_ff <= 1'b0;
         end else begin
            rd_valid_ff <= issue;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pages_ff    <= pages_in;
         too_big_ff  <= too_big_in;
         page_ff     <= PW'(page_wide);
         in_range_ff <= in_range_in;
         rd_word_ff  <= '0;
         len_ff      <= '0;
         first_ff    <= '0;
      end else if (cmd.mark_init) begin
         rd_word_ff   <= WCW'(hit_start_v >> WS);
         start_ff     <= hit_start_v;
         lo_ff        <= hit_start_v;
         hi_ff        <= alloc_hi;
         last_word_ff <= WAW'((alloc_hi - PCW'(1)) >> WS);
         set_ff       <= 1'b1;
      end else if (cmd.free_init) begin
         rd_word_ff   <= WCW'(page_ff >> WS);
         lo_ff        <= page_ff;
         hi_ff        <= free_hi;
         last_word_ff <= WAW'((free_hi - PCW'(1)) >> WS);
         set_ff       <= 1'b0;
      end else if (issue) begin
         rd_word_ff <= rd_word_ff + WCW'(1);
         dword_ff   <= rd_word_ff[WAW-1:0];
      end
      if (cmd.scan_run && rd_valid_ff && !hit_v) begin
         len_ff   <= len_v;
         first_ff <= first_v;
      end
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_kind)
            ffpra_pkg::RSP_ALLOC: begin
               rsp_ff.block_address <= alloc_addr;
               rsp_ff.status        <= ffpra_pkg::STATUS_DONE;
            end
            ffpra_pkg::RSP_FAIL: begin
               rsp_ff.block_address <= '0;
               rsp_ff.status        <= ffpra_pkg::STATUS_NO_ROOM;
            end
            default: begin
               rsp_ff.block_address <= '0;
               rsp_ff.status        <= ffpra_pkg::STATUS_DONE;
            end
         endcase
      end
   end

   assign sts.too_big    = too_big_ff;
   assign sts.in_range   = in_range_ff;
   assign sts.run_zero   = (rl_rd_ff == '0);
   assign sts.scan_hit   = rd_valid_ff && hit_v;
   assign sts.scan_end   = rd_valid_ff && !hit_v && (dword_ff == LAST_WORD);
   assign sts.walk_done  = rd_valid_ff && (dword_ff == last_word_ff);
   assign sts.clear_done = (clr_ff == LAST_PAGE);

   assign rsp_data = rsp_ff;

endmodule

FILE: sv/ffpra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpra_ctrl
// Controller: clearing pass, request sequencing and result handshake.
// ----------------------------------------------------------------------------
module ffpra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_mode,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  ffpra_pkg::sts_type sts,
   output ffpra_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR      = 8'b0000_0001,
      ST_IDLE       = 8'b0000_0010,
      ST_ALLOC_SCAN = 8'b0000_0100,
      ST_ALLOC_MARK = 8'b0000_1000,
      ST_FREE_LOOK  = 8'b0001_0000,
      ST_FREE_EVAL  = 8'b0010_0000,
      ST_FREE_WALK  = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   ffpra_pkg::rsp_kind_type   outcome_ff, outcome_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.rsp_kind = outcome_ff;
      state_in     = state_ff;
      outcome_in   = outcome_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = (req_mode == ffpra_pkg::MODE_ALLOC) ? ST_ALLOC_SCAN
                                                              : ST_FREE_LOOK;
            end
         end
         ST_ALLOC_SCAN: begin
            if (sts.too_big) begin
               outcome_in = ffpra_pkg::RSP_FAIL;
               state_in   = ST_FINISH;
            end else begin
               cmd.scan_run = 1'b1;
               if (sts.scan_hit) begin
                  cmd.mark_init = 1'b1;
                  state_in      = ST_ALLOC_MARK;
               end else if (sts.scan_end) begin
                  outcome_in = ffpra_pkg::RSP_FAIL;
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_ALLOC_MARK: begin
            cmd.walk_run = 1'b1;
            if (sts.walk_done) begin
               outcome_in = ffpra_pkg::RSP_ALLOC;
               state_in   = ST_FINISH;
            end
         end
         ST_FREE_LOOK: begin
            state_in = ST_FREE_EVAL;
         end
         ST_FREE_EVAL: begin
            outcome_in = ffpra_pkg::RSP_FREE;
            if (!sts.in_range || sts.run_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.free_init = 1'b1;
               state_in      = ST_FREE_WALK;
            end
         end
         ST_FREE_WALK: begin
            cmd.walk_run = 1'b1;
            if (sts.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         outcome_ff   <= ffpra_pkg::RSP_FREE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         outcome_ff   <= outcome_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not start work");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result pending during clearing pass");

   a_hit_end_exclusive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_SCAN) |-> !(sts.scan_hit && sts.scan_end))
      else $error("scan reported hit and end together");
`endif

endmodule

FILE: sv/first_fit_page_run_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator
// First-fit allocator of page runs over a page-used bitmap with a run-length
// table per start page.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall  ffpra_pkg::req_type (mode, count, addr)
//   rsp      out  rsp_valid/rsp_stall  ffpra_pkg::rsp_type (address, status)
//   csr      in   csr_wr_en            csr_index, csr_wr_data
//
// Allocate: bitmap scan at 8 pages per cycle up to the hit, over at most
//   ceil(NUM_PAGES/8) words, then a walk that marks the run's bitmap words.
// No room: the whole bitmap is scanned when the page count fits the table.
// Free: run-length lookup; if a run exists, a walk clears its bitmap words.
// After reset a clearing pass over every page runs; req_stall stays high.
// One transaction is in work at a time; a result held on rsp does not block
//   the next request, only the one after it.
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator #(
   parameter int unsigned NUM_PAGES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ffpra_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ffpra_pkg::ADDR_W-1:0]      csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ffpra_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ffpra_pkg::rsp_type                rsp_data
);

   ffpra_pkg::cmd_type cmd;
   ffpra_pkg::sts_type sts;

   ffpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffpra_dp #(
      .NUM_PAGES (NUM_PAGES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: test/tb_first_fit_page_run_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_page_run_allocator
// Self-checking bench for the first-fit page run allocator. A short table of
// directed transactions covers the edge cases at reset settings. Then random
// phases run under several register settings, extremes included. Every
// result is checked against its table row or a page map mirror kept in the
// bench, with random idle cycles on both channels outside the quiet phase.
// ----------------------------------------------------------------------------
module tb_first_fit_page_run_allocator;

   localparam int unsigned NUM_PAGES       = 4096;
   localparam int unsigned ITEMS_PER_PHASE = 180;
   localparam int unsigned CYCLE_LIMIT     = 10_000_000;
   localparam int unsigned SETTLE_CYCLES   = 1200;

   typedef struct packed {
      ffpra_pkg::req_type request;
      logic               typed;
      ffpra_pkg::rsp_type result;
   } script_row_type;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              csr_wr_en   = 1'b0;
   logic [ffpra_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [ffpra_pkg::ADDR_W-1:0]      csr_wr_data = '0;
   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   ffpra_pkg::req_type                req_data    = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   ffpra_pkg::rsp_type                rsp_data;

   bit                            mirror_used [NUM_PAGES];
   bit [12:0]                     mirror_run_len [NUM_PAGES];
   logic [ffpra_pkg::SHIFT_W-1:0] mirror_count_shift = ffpra_pkg::COUNT_SHIFT_RST;
   logic [ffpra_pkg::SHIFT_W-1:0] mirror_page_shift  = ffpra_pkg::PAGE_SHIFT_RST;
   logic [ffpra_pkg::ADDR_W-1:0]  mirror_base        = ffpra_pkg::BASE_ADDRESS_RST;

   ffpra_pkg::rsp_type pending_grants[$];
   script_row_type     script[$];
   ffpra_pkg::rsp_type oldest;
   int unsigned        error_count  = 0;
   int unsigned        cycle_count  = 0;
   bit                 stall_enable = 1'b1;
   bit                 presenting   = 1'b0;

   first_fit_page_run_allocator #(
      .NUM_PAGES(NUM_PAGES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mirror of the page map: returns the result and updates the state
   function automatic ffpra_pkg::rsp_type apply_page_request(
         input ffpra_pkg::req_type request);
      ffpra_pkg::rsp_type result;
      longint unsigned    want;
      longint unsigned    run;
      int unsigned        first;
      int unsigned        p;
      int unsigned        k;
      int unsigned        page;
      bit                 found;
      result = '{block_address: '0, status: ffpra_pkg::STATUS_DONE};
      if (request.mode == ffpra_pkg::MODE_ALLOC) begin
         want  = (64'(request.byte_count) >> mirror_count_shift) + 64'd1;
         found = 1'b0;
         run   = 0;
         first = 0;
         if (want <= NUM_PAGES) begin
            for (p = 0; p < NUM_PAGES && !found; p++) begin
               if (mirror_used[p]) begin
                  run = 0;
               end else begin
                  if (run == 0) first = p;
                  run++;
                  if (run == want) found = 1'b1;
               end
            end
         end
         if (!found) begin
            result.status = ffpra_pkg::STATUS_NO_ROOM;
         end else begin
            for (k = 0; k < want; k++) mirror_used[first + k] = 1'b1;
            mirror_run_len[first] = want[12:0];
            result.block_address = mirror_base + (32'(first) << mirror_page_shift);
         end
      end else if (request.address >= mirror_base) begin
         page = (request.address - mirror_base) >> mirror_page_shift;
         if (page < NUM_PAGES) begin
            for (k = 0; k < mirror_run_len[page] && page + k < NUM_PAGES; k++)
               mirror_used[page + k] = 1'b0;
            mirror_run_len[page] = '0;
         end
      end
      return result;
   endfunction

   function automatic int find_live_start();
      int unsigned origin;
      int unsigned n;
      int unsigned p;
      origin = $urandom_range(NUM_PAGES - 1);
      for (n = 0; n < NUM_PAGES; n++) begin
         p = (origin + n) % NUM_PAGES;
         if (mirror_run_len[p] != 0) return p;
      end
      return -1;
   endfunction

   function automatic ffpra_pkg::req_type random_request();
      ffpra_pkg::req_type request;
      int unsigned        pick;
      int unsigned        pages;
      int unsigned        len;
      int                 live;
      longint unsigned    span;
      longint unsigned    fill;
      logic [31:0]        page_mask;
      request.mode       = ffpra_pkg::MODE_ALLOC;
      request.byte_count = $urandom;
      request.address    = $urandom;
      page_mask = 32'((64'd1 << mirror_page_shift) - 64'd1);
      pick = $urandom_range(99);
      live = find_live_start();
      if (pick < 45 || (pick < 85 && live < 0)) begin
         pages = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
         span  = 64'hFFFF_FFFF >> mirror_count_shift;
         fill  = pages - 1;
         if (fill > span) fill = span;
         request.byte_count = 32'(fill << mirror_count_shift)
            | ($urandom & 32'((64'd1 << mirror_count_shift) - 64'd1));
      end else if (pick < 80) begin
         request.mode    = ffpra_pkg::MODE_FREE;
         request.address = mirror_base + (32'(live) << mirror_page_shift);
         if ($urandom_range(1) == 1) request.address += $urandom & page_mask;
      end else if (pick < 85) begin
         // inside the run, or the page just past it
         len = mirror_run_len[live];
         request.mode    = ffpra_pkg::MODE_FREE;
         request.address = mirror_base
            + (32'(live + $urandom_range(len, 1)) << mirror_page_shift);
      end else if (pick < 90) begin
         request.mode = ffpra_pkg::MODE_FREE;
      end else if (pick >= 95) begin
         request.mode    = ffpra_pkg::MODE_FREE;
         request.address = mirror_base
            + (32'($urandom_range(NUM_PAGES + 100)) << mirror_page_shift);
      end
      return request;
   endfunction

   function automatic script_row_type step_row(input logic mode, input logic [31:0] bytes,
         input logic [31:0] addr, input logic typed, input logic [31:0] block_address,
         input logic status);
      script_row_type row;
      row.request = '{mode: mode, byte_count: bytes, address: addr};
      row.typed   = typed;
      row.result  = '{block_address: block_address, status: status};
      return row;
   endfunction

   task automatic send_request(input ffpra_pkg::req_type request, input logic typed,
         input ffpra_pkg::rsp_type typed_result);
      ffpra_pkg::rsp_type predicted;
      if (stall_enable && $urandom_range(99) < 6) begin
         if (presenting) req_valid <= 1'b0;
         presenting = 1'b0;
         repeat ($urandom_range(70, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= request;
      presenting = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_page_request(request);
      pending_grants.push_back(typed ? typed_result : predicted);
   endtask

   task automatic await_all_results();
      if (presenting) req_valid <= 1'b0;
      presenting = 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   // upper data bits of the shift registers are don't-care
   task automatic program_allocator(input logic [4:0] count_shift,
         input logic [4:0] page_shift, input logic [31:0] base);
      csr_wr_en   <= 1'b1;
      csr_index   <= ffpra_pkg::CSR_COUNT_SHIFT;
      csr_wr_data <= {27'($urandom), count_shift};
      @(posedge clock);
      mirror_count_shift = count_shift;
      csr_index   <= ffpra_pkg::CSR_PAGE_SHIFT;
      csr_wr_data <= {27'($urandom), page_shift};
      @(posedge clock);
      mirror_page_shift = page_shift;
      csr_index   <= ffpra_pkg::CSR_BASE_ADDRESS;
      csr_wr_data <= base;
      @(posedge clock);
      mirror_base = base;
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [4:0] count_shift, input logic [4:0] page_shift,
         input logic [31:0] base, input bit quiet);
      ffpra_pkg::req_type request;
      int                 live;
      await_all_results();
      // flat map so every leftover run can be freed by its page number
      if (find_live_start() >= 0) begin
         program_allocator(mirror_count_shift, '0, '0);
         live = find_live_start();
         while (live >= 0) begin
            request = '{mode: ffpra_pkg::MODE_FREE, byte_count: $urandom,
                        address: 32'(live)};
            send_request(request, 1'b0, '0);
            live = find_live_start();
         end
         await_all_results();
      end
      program_allocator(count_shift, page_shift, base);
      stall_enable = !quiet;
      repeat (ITEMS_PER_PHASE) begin
         send_request(random_request(), 1'b0, '0);
         if ($urandom_range(149) == 0) await_all_results();
      end
      stall_enable = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= stall_enable && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data.block_address, '0);
         end else begin
            oldest = pending_grants.pop_front();
            if (rsp_data.block_address !== oldest.block_address)
               report_mismatch("block_address", rsp_data.block_address,
                               oldest.block_address);
            if (rsp_data.status !== oldest.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(oldest.status));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[first_fit_page_run_allocator] ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'h0, 32'h0, 1'b1,
                                ffpra_pkg::BASE_ADDRESS_RST, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'hFFF, 32'h0, 1'b0,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'h1000, 32'h0, 1'b0,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                '0, ffpra_pkg::STATUS_NO_ROOM));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'hFF_F000, 32'h0, 1'b1,
                                '0, ffpra_pkg::STATUS_NO_ROOM));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0200_0200, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h01FF_FFFF, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0220_0000, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'h0200_0401, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0200_0600, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0200_0200, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'h2FFF, 32'hFFFF_FFFF, 1'b0,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'h0, 32'h0, 1'b0,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'hFFFF_FFFF, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'hFF_A000, 32'h0, 1'b0,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'h0, 32'h0, 1'b1,
                                '0, ffpra_pkg::STATUS_NO_ROOM));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0200_0A00, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0200_0000, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0200_0200, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0200_0800, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_ALLOC, 32'hFF_F000, 32'h0, 1'b1,
                                ffpra_pkg::BASE_ADDRESS_RST, ffpra_pkg::STATUS_DONE));
      script.push_back(step_row(ffpra_pkg::MODE_FREE, 32'h0, 32'h0200_0000, 1'b1,
                                '0, ffpra_pkg::STATUS_DONE));
      foreach (script[i])
         send_request(script[i].request, script[i].typed, script[i].result);

      run_phase(5'd0, 5'd0, 32'h0000_0000, 1'b0);
      run_phase(5'd31, 5'd31, 32'hFFFF_FFFF, 1'b0);
      run_phase(5'd4, 5'd12, 32'h8000_0000, 1'b0);
      run_phase(5'd9, 5'd20, 32'hFFFF_F000, 1'b0);
      run_phase(5'd31, 5'd0, 32'h0000_0000, 1'b0);
      run_phase(5'd0, 5'd31, 32'h0000_0000, 1'b0);
      run_phase(ffpra_pkg::COUNT_SHIFT_RST, ffpra_pkg::PAGE_SHIFT_RST,
                ffpra_pkg::BASE_ADDRESS_RST, 1'b1);
      run_phase(5'($urandom_range(15)), 5'($urandom_range(16)), $urandom, 1'b0);

      await_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[first_fit_page_run_allocator] OK");
      end else begin
         $display("[first_fit_page_run_allocator] ERROR");
      end
      $finish;
   end

endmodule
